/* design/amss_pkg.sv */
// Shared types and constants for the adjacency mutual source/sink scan block.
package amss_pkg;

	localparam int ROW_W = 32;
	localparam int IDX_W = 5;
	localparam int CNT_W = 6;

	localparam logic [CNT_W-1:0] NODE_COUNT_RST = 6'd32;

	localparam logic RESULT_ROW   = 1'b0;
	localparam logic RESULT_FINAL = 1'b1;

	// One accepted row's worth of results, waiting for the output side.
	typedef struct packed {
		logic [IDX_W-1:0] node_index;
		logic [ROW_W-1:0] mutual_mask;
		logic             no_outgoing;
		logic             is_final;
		logic [ROW_W-1:0] no_incoming_mask;
	} amss_rec_t;

endpackage

/* design/amss_lane.sv */
// One lane: holds a stored matrix row and checks it for the reverse edge of the current row.
module amss_lane (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [amss_pkg::ROW_W-1:0] wr_row,
	input  logic [amss_pkg::IDX_W-1:0] col,
	input  logic                      below,
	input  logic                      fwd_edge,
	output logic                      hit
);
	import amss_pkg::*;

	logic [ROW_W-1:0] row_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			row_q <= wr_row;
		end
	end

	// An edge is mutual when this lane's node is earlier, the current row points
	// to it, and its stored row points back to the current row.
	assign hit = below & fwd_edge & row_q[col];

endmodule

/* design/amss_merge.sv */
// Result queue: buffers per-row records and emits one or two result transactions for each.
module amss_merge (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  amss_pkg::amss_rec_t        push_rec,
	output logic                       push_ready,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       result_kind,
	output logic [amss_pkg::IDX_W-1:0] node_index,
	output logic [amss_pkg::ROW_W-1:0] mutual_mask,
	output logic                       no_outgoing,
	output logic [amss_pkg::ROW_W-1:0] no_incoming_mask,
	output logic                       last_of_run
);
	import amss_pkg::*;

	amss_rec_t  ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       phase_q;
	amss_rec_t  head;
	logic       out_take;
	logic       pop;

	assign head       = ent_q[rd_ptr_q];
	assign push_ready = (count_q != 2'd2);
	assign out_valid  = (count_q != 2'd0);
	assign out_take   = out_valid & out_ready;
	// The final row stays at the head until its second transaction is taken.
	assign pop        = out_take & (phase_q | ~head.is_final);

	always_comb begin
		result_kind      = phase_q ? RESULT_FINAL : RESULT_ROW;
		node_index       = phase_q ? '0 : head.node_index;
		mutual_mask      = phase_q ? '0 : head.mutual_mask;
		no_outgoing      = phase_q ? 1'b0 : head.no_outgoing;
		no_incoming_mask = phase_q ? head.no_incoming_mask : '0;
		last_of_run      = phase_q | ~head.is_final;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
			phase_q  <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
				phase_q  <= 1'b0;
			end else if (out_take && head.is_final) begin
				phase_q <= 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result queue count out of range");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2) |-> !push)
		else $error("push into a full result queue");

	a_phase_final: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (out_valid && head.is_final))
		else $error("second result pending without a final row at the head");

	a_final_then_summary: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && !phase_q && head.is_final) |=> (out_valid && phase_q))
		else $error("final row transaction not followed by its summary");

endmodule

/* design/adjacency_mutual_source_sink_scan_top.sv */
// Top level of the adjacency mutual source/sink scan block.
// Usage: rows of a directed adjacency matrix enter on the in channel (row_index,
// row_bits), one transaction per row, in ascending order from row 0 up to
// node_count-1. The cfg channel writes node_count (1..32) while the block is idle.
// Each in-range row gives one row result on the out channel: the mask of
// earlier nodes with edges both ways and a flag for a row with only its
// self-loop. The row node_count-1 gives a second, summary transaction with the
// mask of nodes that no other node points to. Rows at or beyond node_count are
// taken and dropped without any result.
// A row result is registered in the result queue before it is offered.
// The block takes one row per cycle while in_ready is high; the last row
// occupies the output for two transactions. Every row is compared against all
// stored rows at once by one lane per node, each lane holding its row in flops.
// A two-entry result queue sits between the sides, so a new row is taken while
// a result waits; when the receiver stalls the queue fills and in_ready drops.
// Reset empties the queue, clears the column record and sets node_count to 32;
// stored rows are not cleared and become meaningful once written.
module adjacency_mutual_source_sink_scan_top #(
	parameter int MAX_NODES = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [amss_pkg::CNT_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [amss_pkg::IDX_W-1:0] row_index,
	input  logic [amss_pkg::ROW_W-1:0] row_bits,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       result_kind,
	output logic [amss_pkg::IDX_W-1:0] node_index,
	output logic [amss_pkg::ROW_W-1:0] mutual_mask,
	output logic                       no_outgoing,
	output logic [amss_pkg::ROW_W-1:0] no_incoming_mask,
	output logic                       last_of_run
);
	import amss_pkg::*;

	localparam int NUM_LANES = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;

	logic [CNT_W-1:0] node_count_q;
	logic [ROW_W-1:0] column_seen_q;
	logic [CNT_W-1:0] eff_count;
	logic [CNT_W-1:0] row_ext;
	logic [ROW_W-1:0] vmask;
	logic [ROW_W-1:0] diag;
	logic [ROW_W-1:0] clean_row;
	logic [ROW_W-1:0] seen_next;
	logic [ROW_W-1:0] mutual;
	logic [NUM_LANES-1:0] lane_hit;
	logic             in_take;
	logic             in_range;
	logic             is_final;
	logic             push_ready;
	amss_rec_t        rec;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			node_count_q <= cfg_data;
		end
	end

	// A count of zero acts as one; larger counts saturate at the lane count.
	always_comb begin
		if (node_count_q == '0) begin
			eff_count = CNT_W'(1);
		end else if (node_count_q > CNT_W'(NUM_LANES)) begin
			eff_count = CNT_W'(NUM_LANES);
		end else begin
			eff_count = node_count_q;
		end
	end

	always_comb begin
		for (int j = 0; j < ROW_W; j++) begin
			vmask[j] = (CNT_W'(j) < eff_count);
		end
	end

	assign row_ext   = {1'b0, row_index};
	assign in_range  = (row_ext < eff_count);
	assign is_final  = (row_ext == (eff_count - CNT_W'(1)));
	assign in_ready  = push_ready;
	assign in_take   = in_valid & in_ready;
	assign diag      = ROW_W'(1) << row_index;
	assign clean_row = (row_bits & vmask) | diag;
	assign seen_next = ((row_index == '0) ? '0 : column_seen_q) | (clean_row & ~diag);

	for (genvar j = 0; j < NUM_LANES; j++) begin : g_lane
		amss_lane u_lane (
			.clk      (clk),
			.wr_en    (in_take && in_range && (row_index == IDX_W'(j))),
			.wr_row   (clean_row),
			.col      (row_index),
			.below    (CNT_W'(j) < row_ext),
			.fwd_edge (clean_row[j]),
			.hit      (lane_hit[j])
		);
	end

	always_comb begin
		mutual = '0;
		for (int j = 0; j < NUM_LANES; j++) begin
			mutual[j] = lane_hit[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_seen_q <= '0;
		end else if (in_take && in_range) begin
			column_seen_q <= seen_next;
		end
	end

	always_comb begin
		rec.node_index       = row_index;
		rec.mutual_mask      = mutual;
		rec.no_outgoing      = (clean_row == diag);
		rec.is_final         = is_final;
		rec.no_incoming_mask = ~seen_next & vmask;
	end

	amss_merge u_merge (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (in_take && in_range),
		.push_rec         (rec),
		.push_ready       (push_ready),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.result_kind      (result_kind),
		.node_index       (node_index),
		.mutual_mask      (mutual_mask),
		.no_outgoing      (no_outgoing),
		.no_incoming_mask (no_incoming_mask),
		.last_of_run      (last_of_run)
	);

endmodule
